@@ hdl/ioera_pkg.sv @@
package ioera_pkg;

  // field widths fixed by the word formats
  localparam int CMD_BITS     = 2;
  localparam int CLIENT_BITS  = 3;
  localparam int ID_BITS      = 32;
  localparam int DATA_BITS    = 32;
  localparam int KIND_BITS    = 2;
  localparam int MASK_BITS    = 8;
  localparam int MAX_CLIENTS  = 2 ** CLIENT_BITS;

  // defaults for the top level parameters
  localparam int NUM_CLIENTS_DEF  = 8;
  localparam int WINDOW_DEF       = 32;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam logic [ID_BITS-1:0] ID_MAX = '1;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_EVENT     = 2'd0,
    CMD_EVENT_END = 2'd1,
    CMD_END       = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_EVENT   = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_UNKNOWN = 2'd2,
    KIND_BEYOND  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]    command;
    logic [CLIENT_BITS-1:0] client;
    logic [ID_BITS-1:0]     seq_id;
    logic [DATA_BITS-1:0]   payload;
  } in_word_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [CLIENT_BITS-1:0] client_out;
    logic [ID_BITS-1:0]     id_out;
    logic [DATA_BITS-1:0]   payload_out;
    logic                   last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic  load;
    logic  insert;
    logic  step;
    logic  out_valid;
    kind_t out_kind;
    logic  out_last;
  } dp_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_BITS-1:0] command;
    logic                known;
    logic                newer;
    logic                beyond;
    logic                hit;
  } dp_status_t;

endpackage

@@ hdl/ioera_dpath.sv @@
module ioera_dpath #(
  parameter int NUM_CLIENTS  = ioera_pkg::NUM_CLIENTS_DEF,
  parameter int WINDOW       = ioera_pkg::WINDOW_DEF,
  parameter int PAYLOAD_BITS = ioera_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [ioera_pkg::MASK_BITS-1:0] cfg_wr_data,
  input  ioera_pkg::in_word_t             item,
  input  ioera_pkg::dp_ctrl_t             ctrl,
  output ioera_pkg::dp_status_t           status,
  output ioera_pkg::out_word_t            result
);
  import ioera_pkg::*;

  localparam int CLIENTS = (NUM_CLIENTS < MAX_CLIENTS) ? NUM_CLIENTS : MAX_CLIENTS;
  localparam int CW      = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int SW      = $clog2(WINDOW);
  localparam int SB      = (PAYLOAD_BITS < DATA_BITS) ? PAYLOAD_BITS : DATA_BITS;

  logic [MASK_BITS-1:0] mask;
  in_word_t             in_reg;
  logic [ID_BITS-1:0]   delivered [CLIENTS];
  logic [SW-1:0]        head      [CLIENTS];
  logic [WINDOW-1:0]    valid     [CLIENTS];
  logic [SB-1:0]        mem       [CLIENTS][WINDOW];
  logic [SB-1:0]        rd_data;
  logic [ID_BITS-1:0]   rel_id;

  logic [CW-1:0]      cidx;
  logic [ID_BITS-1:0] d;
  logic [SW-1:0]      h;
  logic [SW-1:0]      h_inc;
  logic [ID_BITS-1:0] ahead;
  logic [SW-1:0]      ahead_m1;
  logic [SW:0]        off_sum;
  logic [SW-1:0]      ins_off;
  logic               do_write;

  assign cidx = in_reg.client[CW-1:0];
  assign d    = delivered[cidx];
  assign h    = head[cidx];

  // head tracks (delivered + 1) mod window
  assign h_inc = (h == SW'(WINDOW - 1)) ? '0 : h + SW'(1);

  assign ahead    = in_reg.seq_id - d;
  assign ahead_m1 = ahead[SW-1:0] - SW'(1);
  assign off_sum  = {1'b0, h} + {1'b0, ahead_m1};
  assign ins_off  = (off_sum >= (SW+1)'(WINDOW)) ? SW'(off_sum - (SW+1)'(WINDOW))
                                                 : off_sum[SW-1:0];

  // first copy wins
  assign do_write = ctrl.insert && !valid[cidx][ins_off];

  always_comb begin
    status.command = in_reg.command;
    status.known   = ({6'd0, in_reg.client} < 9'(NUM_CLIENTS)) &&
                     mask[in_reg.client];
    status.newer   = in_reg.seq_id > d;
    status.beyond  = ahead > ID_BITS'(WINDOW);
    status.hit     = (d != ID_MAX) && valid[cidx][h];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (cfg_wr_en) begin
      mask <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      in_reg <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CLIENTS; c++) begin
        delivered[c] <= '0;
        head[c]      <= SW'(1);
        valid[c]     <= '0;
      end
    end else begin
      if (do_write) begin
        valid[cidx][ins_off] <= 1'b1;
      end
      if (ctrl.step) begin
        valid[cidx][h]  <= 1'b0;
        delivered[cidx] <= d + ID_BITS'(1);
        head[cidx]      <= h_inc;
      end
    end
  end

  // payload store, registered read
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[cidx][ins_off] <= in_reg.payload[SB-1:0];
    end
    if (ctrl.step) begin
      rd_data <= mem[cidx][h];
      rel_id  <= d + ID_BITS'(1);
    end
  end

  always_comb begin
    result.kind        = ctrl.out_kind;
    result.client_out  = in_reg.client;
    result.last        = ctrl.out_last;
    result.payload_out = '0;
    case (ctrl.out_kind)
      KIND_EVENT: begin
        result.id_out      = rel_id;
        result.payload_out = DATA_BITS'(rd_data);
      end
      KIND_ACK: begin
        result.id_out = d;
      end
      KIND_UNKNOWN: begin
        result.id_out = (in_reg.command == CMD_END) ? '0 : in_reg.seq_id;
      end
      default: begin
        result.id_out = in_reg.seq_id;
      end
    endcase
  end

endmodule

@@ hdl/ioera_ctrl.sv @@
module ioera_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  ioera_pkg::dp_status_t status,
  output ioera_pkg::dp_ctrl_t   ctrl
);
  import ioera_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_WALK  = 4'b0100,
    S_ACK   = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   rel_pend, rel_pend_next;
  logic   released, released_next;
  logic   has_event;
  logic   has_end;

  assign busy = (state != S_IDLE);

  always_comb begin
    has_event = status.command inside {CMD_EVENT, CMD_EVENT_END};
    has_end   = status.command inside {CMD_EVENT_END, CMD_END};
  end

  always_comb begin
    state_next     = state;
    rel_pend_next  = rel_pend;
    released_next  = released;
    ctrl.load      = 1'b0;
    ctrl.insert    = 1'b0;
    ctrl.step      = 1'b0;
    ctrl.out_valid = 1'b0;
    ctrl.out_kind  = KIND_EVENT;
    ctrl.out_last  = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        rel_pend_next = 1'b0;
        released_next = 1'b0;
        if (status.command == CMD_NONE) begin
          state_next = S_IDLE;
        end else if (!status.known) begin
          ctrl.out_valid = 1'b1;
          ctrl.out_kind  = KIND_UNKNOWN;
          ctrl.out_last  = 1'b1;
          state_next     = S_IDLE;
        end else begin
          if (has_event && status.newer) begin
            if (status.beyond) begin
              // last unless a release is certain to follow
              ctrl.out_valid = 1'b1;
              ctrl.out_kind  = KIND_BEYOND;
              ctrl.out_last  = !(has_end && status.hit);
            end else begin
              ctrl.insert = 1'b1;
            end
          end
          state_next = has_end ? S_WALK : S_IDLE;
        end
      end
      S_WALK: begin
        // previous step's payload is out of the store now
        ctrl.out_valid = rel_pend;
        ctrl.out_kind  = KIND_EVENT;
        if (status.hit) begin
          ctrl.step     = 1'b1;
          rel_pend_next = 1'b1;
          released_next = 1'b1;
        end else begin
          rel_pend_next = 1'b0;
          state_next    = released ? S_ACK : S_IDLE;
        end
      end
      S_ACK: begin
        ctrl.out_valid = 1'b1;
        ctrl.out_kind  = KIND_ACK;
        ctrl.out_last  = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rel_pend <= 1'b0;
      released <= 1'b0;
    end else begin
      state    <= state_next;
      rel_pend <= rel_pend_next;
      released <= released_next;
    end
  end

endmodule

@@ hdl/in_order_event_reorder_ack_unit.sv @@
// channel   signals                      accepted when
// -------   --------------------------   -----------------------------------
// input     start, item                  rising edge with start high, busy low
// result    strobe, result               every edge that ends a strobe cycle
// config    cfg_wr_en, cfg_wr_data       rising edge with cfg_wr_en high
//
// a word is checked in the cycle after it is taken; a plain event, an unknown client
// or an unused command ends there
// an end of packet then walks the window, one release per registered store read,
// then leaves the walk and gives the ack only when at least one event was released
// synchronous reset clears mask, ids and occupancy at once; results cannot stall
module in_order_event_reorder_ack_unit #(
  parameter int NUM_CLIENTS  = ioera_pkg::NUM_CLIENTS_DEF,
  parameter int WINDOW       = ioera_pkg::WINDOW_DEF,
  parameter int PAYLOAD_BITS = ioera_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  ioera_pkg::in_word_t             item,
  output logic                            strobe,
  output ioera_pkg::out_word_t            result,
  input  logic                            cfg_wr_en,
  input  logic [ioera_pkg::MASK_BITS-1:0] cfg_wr_data
);
  import ioera_pkg::*;

  // command and status between the sequencer and the datapath
  dp_ctrl_t   ctrl;
  dp_status_t status;

  ioera_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .ctrl   (ctrl)
  );

  // delivered ids, window heads, occupancy bits and payload store
  ioera_dpath #(
    .NUM_CLIENTS  (NUM_CLIENTS),
    .WINDOW       (WINDOW),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .ctrl        (ctrl),
    .status      (status),
    .result      (result)
  );

  // a result word is shown for one cycle only
  assign strobe = ctrl.out_valid;

  // results only appear while a word is in work
  a_strobe_busy : assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result strobe while idle");

  // an accepted word always occupies the block next cycle
  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");

  // a released event is always followed by at least the ack
  a_event_not_last : assert property (@(posedge clk) disable iff (rst)
    (strobe && result.kind == KIND_EVENT) |-> !result.last)
    else $error("released event marked last");

  // the ack closes the word's results
  a_ack_last : assert property (@(posedge clk) disable iff (rst)
    (strobe && result.kind == KIND_ACK) |-> (result.last && $past(strobe)))
    else $error("ack not last or not after a release");

  // nothing follows the last result of a word
  a_last_gap : assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |=> !strobe)
    else $error("result after last");

endmodule
